>>> sv/rhsi_pkg.sv
// ----------------------------------------------------------------------------
// rhsi_pkg: shared types and constants for the rgb to hsi converter
// request items travelling through the divider and hue cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package rhsi_pkg;

    localparam int CH_W      = 8;
    localparam int SUM_W     = 10;
    localparam int NUM_W     = 18;
    localparam int NSQ_W     = 18;
    localparam int DEN_W     = 17;
    localparam int DIV_STEPS = 8;
    localparam int HUE_STEPS = 127;
    localparam int CNT_W     = $clog2(HUE_STEPS + 1);
    localparam int HUE_MAX   = 254;
    localparam int INV3_MUL  = 683;
    localparam int INV3_SH   = 11;
    localparam int SAT_SCALE = 255;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint ROT_C   = 64'sd1073415892;
    localparam longint ROT_S   = 64'sd26454260;

    // request in the divider chain
    typedef struct packed {
        logic               valid;
        logic               black;
        logic               bgt;
        logic               n_pos;
        logic               n_zero;
        logic [NSQ_W-1:0]   nsq;
        logic [DEN_W-1:0]   den;
        logic [SUM_W-1:0]   sum;
        logic [NUM_W-1:0]   rem;
        logic [CH_W-1:0]    quo;
        logic [CH_W-1:0]    inten;
    } t_div_item;

    // request in the hue cell chain
    typedef struct packed {
        logic               valid;
        logic               bgt;
        logic               n_pos;
        logic               n_zero;
        logic [NSQ_W-1:0]   nsq;
        logic [DEN_W-1:0]   den;
        logic [CNT_W-1:0]   cnt;
        logic [CH_W-1:0]    sat;
        logic [CH_W-1:0]    inten;
    } t_hue_item;

    function automatic longint rhsi_round_shift(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    // q2.20 cosine threshold for step k, built by repeated q30 rotation
    function automatic longint rhsi_thresh(input int k);
        longint c;
        longint s;
        longint nc;
        longint ns;
        c = Q30_ONE;
        s = 64'sd0;
        for (int i = 1; i <= k; i++) begin
            nc = rhsi_round_shift(c * ROT_C - s * ROT_S, 30);
            ns = rhsi_round_shift(s * ROT_C + c * ROT_S, 30);
            c  = nc;
            s  = ns;
        end
        return rhsi_round_shift(c, 10);
    endfunction

endpackage

`default_nettype wire

>>> sv/rgb_to_hsi_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel: 8-bit rgb to 8-bit hsi pixel converter
// one front stage, eight divider cells, 127 hue threshold cells, output register
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the cell chain is not frozen by a stall
// the whole chain freezes only while a result waits under stall
// reset (synchronous, active low) empties the chain; no request is in flight after
`default_nettype none

module rgb_to_hsi_pixel (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [rhsi_pkg::CH_W-1:0] i_red,
    input  wire logic [rhsi_pkg::CH_W-1:0] i_green,
    input  wire logic [rhsi_pkg::CH_W-1:0] i_blue,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [rhsi_pkg::CH_W-1:0]      o_hue_code,
    output logic [rhsi_pkg::CH_W-1:0]      o_saturation_code,
    output logic [rhsi_pkg::CH_W-1:0]      o_intensity_code
);
    import rhsi_pkg::*;

    // chain advances unless a finished result is held by the consumer
    logic w_adv;

    t_div_item w_div [0:DIV_STEPS];
    t_hue_item w_hue [0:HUE_STEPS];

    logic              r_valid;
    logic [CH_W-1:0]   r_hue;
    logic [CH_W-1:0]   r_sat;
    logic [CH_W-1:0]   r_int;
    logic [CH_W-1:0]   n_hue;

    assign w_adv   = !(r_valid && i_stall);
    assign o_stall = !w_adv;

    rhsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_item  (w_div[0])
    );

    // saturation divider, msb first
    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
        rhsi_div_cell #(
            .BIT (DIV_STEPS - 1 - gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_item  (w_div[gi]),
            .o_item  (w_div[gi+1])
        );
    end

    // hand over into the hue chain; black pixel forces saturation zero
    always_comb begin
        w_hue[0].valid  = w_div[DIV_STEPS].valid;
        w_hue[0].bgt    = w_div[DIV_STEPS].bgt;
        w_hue[0].n_pos  = w_div[DIV_STEPS].n_pos;
        w_hue[0].n_zero = w_div[DIV_STEPS].n_zero;
        w_hue[0].nsq    = w_div[DIV_STEPS].nsq;
        w_hue[0].den    = w_div[DIV_STEPS].den;
        w_hue[0].cnt    = '0;
        w_hue[0].sat    = w_div[DIV_STEPS].black ? '0 : w_div[DIV_STEPS].quo;
        w_hue[0].inten  = w_div[DIV_STEPS].inten;
    end

    // one cell per hue threshold
    for (genvar gk = 0; gk < HUE_STEPS; gk++) begin : g_hue
        rhsi_hue_cell #(
            .K (gk + 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_item  (w_hue[gk]),
            .o_item  (w_hue[gk+1])
        );
    end

    // zero denominator (grey or black) gives hue zero; blue above green mirrors
    always_comb begin
        if (w_hue[HUE_STEPS].den == '0) begin
            n_hue = '0;
        end else if (w_hue[HUE_STEPS].bgt) begin
            n_hue = CH_W'(HUE_MAX) - CH_W'(w_hue[HUE_STEPS].cnt);
        end else begin
            n_hue = CH_W'(w_hue[HUE_STEPS].cnt);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_hue[HUE_STEPS].valid;
            r_hue   <= n_hue;
            r_sat   <= w_hue[HUE_STEPS].sat;
            r_int   <= w_hue[HUE_STEPS].inten;
        end
    end

    assign o_valid           = r_valid;
    assign o_hue_code        = r_hue;
    assign o_saturation_code = r_sat;
    assign o_intensity_code  = r_int;

    // a delivered result carries fully known codes
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_hue_code, o_saturation_code, o_intensity_code}))
        else $error("result with unknown bits");

    // hue never reaches full scale
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_code != 8'hFF))
        else $error("hue code out of range");

    // a frozen chain keeps its front request
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && $past(i_rst_n)) |=> $stable(w_div[0].valid))
        else $error("front stage moved while frozen");

endmodule

`default_nettype wire

>>> sv/rhsi_front.sv
// ----------------------------------------------------------------------------
// rhsi_front: input stage
// forms and registers sum, minimum terms, intensity, hue numerator and denominator
// ----------------------------------------------------------------------------
`default_nettype none

module rhsi_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [rhsi_pkg::CH_W-1:0] i_red,
    input  wire logic [rhsi_pkg::CH_W-1:0] i_green,
    input  wire logic [rhsi_pkg::CH_W-1:0] i_blue,
    output rhsi_pkg::t_div_item         o_item
);
    import rhsi_pkg::*;

    t_div_item r_item;
    t_div_item n_item;

    logic [SUM_W-1:0]     w_sum;
    logic [CH_W-1:0]      w_min;
    logic [SUM_W-1:0]     w_rest;
    logic signed [10:0]   w_n;
    logic signed [21:0]   w_nsq;
    logic signed [9:0]    w_rg;
    logic signed [9:0]    w_rb;
    logic signed [9:0]    w_gb;
    logic signed [19:0]   w_den;
    logic [19:0]          w_i3;

    always_comb begin
        w_sum  = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
        w_min  = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blue < w_min) w_min = i_blue;
        w_rest = w_sum - SUM_W'(3 * w_min);
        w_n    = 11'(signed'({3'b0, i_red}) * 2) - signed'({3'b0, i_green})
                 - signed'({3'b0, i_blue});
        w_nsq  = w_n * w_n;
        w_rg   = signed'({2'b0, i_red}) - signed'({2'b0, i_green});
        w_rb   = signed'({2'b0, i_red}) - signed'({2'b0, i_blue});
        w_gb   = signed'({2'b0, i_green}) - signed'({2'b0, i_blue});
        w_den  = w_rg * w_rg + w_rb * w_gb;
        w_i3   = 20'(w_sum) * 20'(INV3_MUL);

        n_item.valid  = i_valid;
        n_item.black  = (w_sum == '0);
        n_item.bgt    = (i_blue > i_green);
        n_item.n_pos  = (w_n > 0);
        n_item.n_zero = (w_n == 0);
        n_item.nsq    = w_nsq[NSQ_W-1:0];
        n_item.den    = w_den[DEN_W-1:0];
        n_item.sum    = w_sum;
        n_item.rem    = NUM_W'({w_rest, 8'b0}) - NUM_W'(w_rest);
        n_item.quo    = '0;
        n_item.inten  = w_i3[INV3_SH +: CH_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

>>> sv/rhsi_div_cell.sv
// ----------------------------------------------------------------------------
// rhsi_div_cell: one restoring division step
// settles one saturation quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module rhsi_div_cell #(
    parameter int BIT = 7
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  rhsi_pkg::t_div_item i_item,
    output rhsi_pkg::t_div_item o_item
);
    import rhsi_pkg::*;

    t_div_item r_item;
    t_div_item n_item;
    logic [NUM_W-1:0] w_dsh;

    always_comb begin
        w_dsh  = NUM_W'(i_item.sum) << BIT;
        n_item = i_item;
        if (i_item.rem >= w_dsh) begin
            n_item.rem      = i_item.rem - w_dsh;
            n_item.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

>>> sv/rhsi_hue_cell.sv
// ----------------------------------------------------------------------------
// rhsi_hue_cell: one hue threshold cell
// compares the hue cosine with a fixed threshold and bumps the bin count
// ----------------------------------------------------------------------------
`default_nettype none

module rhsi_hue_cell #(
    parameter int K = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  rhsi_pkg::t_hue_item i_item,
    output rhsi_pkg::t_hue_item o_item
);
    import rhsi_pkg::*;

    localparam longint     T     = rhsi_thresh(K);
    localparam longint     TMAG  = (T < 0) ? -T : T;
    localparam logic [63:0] TSQ4 = 64'(4 * TMAG * TMAG);
    localparam int         TSGN  = (T > 0) ? 1 : ((T < 0) ? -1 : 0);

    t_hue_item   r_item;
    t_hue_item   n_item;
    logic [63:0] w_lhs;
    logic [63:0] w_rhs;
    logic [1:0]  w_nsgn;
    logic        w_lt;
    logic        w_eq;
    logic        w_inc;

    always_comb begin
        // sign codes: 0 zero, 1 positive, 2 negative
        w_nsgn = i_item.n_zero ? 2'd0 : (i_item.n_pos ? 2'd1 : 2'd2);
        w_lhs  = {6'b0, i_item.nsq, 40'b0};
        w_rhs  = TSQ4 * 64'(i_item.den);
        if (i_item.n_zero || (i_item.n_pos && TSGN != 1) || (!i_item.n_pos && TSGN != -1)) begin
            w_eq = (w_nsgn == 2'd0) && (TSGN == 0);
            case (w_nsgn)
                2'd0:    w_lt = (TSGN > 0);
                2'd1:    w_lt = 1'b0;
                default: w_lt = (TSGN != -1);
            endcase
        end else if (i_item.n_pos) begin
            w_lt = (w_lhs < w_rhs);
            w_eq = (w_lhs == w_rhs);
        end else begin
            w_lt = (w_rhs < w_lhs);
            w_eq = (w_lhs == w_rhs);
        end
        w_inc      = i_item.bgt ? w_lt : (w_lt || w_eq);
        n_item     = i_item;
        n_item.cnt = i_item.cnt + CNT_W'(w_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire
